[sv/msfp_pkg.sv]
package msfp_pkg;

    typedef enum logic [2:0] {
        KIND_GENERAL,
        KIND_LOWER,
        KIND_UPPER,
        KIND_HESS,
        KIND_BAND_LO,
        KIND_BAND_UP,
        KIND_BAND_GEN,
        KIND_INVALID
    } msfp_kind_t;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_KIND,
        ERR_SUBDIAG,
        ERR_SUPERDIAG,
        ERR_FROM,
        ERR_TO,
        ERR_COLS,
        ERR_LDIM
    } msfp_err_t;

    typedef enum logic [2:0] {
        REG_KIND,
        REG_SUBDIAG,
        REG_SUPERDIAG,
        REG_FROM,
        REG_TO,
        REG_ROWS,
        REG_COLS,
        REG_LDIM
    } msfp_reg_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_CHECK,
        DS_STEP,
        DS_DIV
    } msfp_dstate_t;

    typedef struct packed {
        msfp_kind_t  kind;
        logic [11:0] kl;
        logic [11:0] ku;
        logic [12:0] m;
        logic [12:0] n;
    } msfp_cfg_t;

    typedef struct packed {
        logic      busy;
        msfp_err_t err;
    } msfp_stat_t;

    typedef struct packed {
        logic        active;
        logic [15:0] value;
    } msfp_item_t;

    typedef struct packed {
        logic signed [7:0] exp;
        logic [10:0]       mant;
    } msfp_unp_t;

    localparam logic [15:0] FP_ONE   = 16'h3C00;
    localparam logic [15:0] FP_SMALL = 16'h0400;
    localparam logic [15:0] FP_QNAN  = 16'h7E00;
    localparam logic [14:0] FP_INF   = 15'h7C00;

    function automatic logic fp_is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [15:0] h);
        return h[14:0] == FP_INF;
    endfunction

    function automatic logic fp_is_zero(input logic [15:0] h);
        return h[14:0] == 15'd0;
    endfunction

    function automatic logic fp_eq(input logic [15:0] a, input logic [15:0] b);
        return (a == b) || (fp_is_zero(a) && fp_is_zero(b));
    endfunction

    // Splits a finite nonzero value into a significand with its leading one at
    // bit 10 and an unbiased exponent.
    function automatic msfp_unp_t fp_unpack(input logic [15:0] h);
        msfp_unp_t  u;
        logic [3:0] lead;
        logic [3:0] sh;
        lead = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h[i])
            begin
                lead = 4'(i);
            end
        end
        sh = 4'd10 - lead;
        if (h[14:10] == 5'd0)
        begin
            u.mant = 11'({1'b0, h[9:0]} << sh);
            u.exp  = 8'(-14 - int'(sh));
        end
        else
        begin
            u.mant = {1'b1, h[9:0]};
            u.exp  = 8'(int'(h[14:10]) - 15);
        end
        return u;
    endfunction

    // Rounds mant * 2^(exp-21), leading one at bit 21, to nearest even.
    function automatic logic [15:0] fp_round(input logic sgn, input logic signed [7:0] exp,
                                             input logic [21:0] mant, input logic sticky);
        logic [7:0]        d;
        logic [4:0]        sh;
        logic [21:0]       q;
        logic [21:0]       rem;
        logic [21:0]       half;
        logic              up;
        logic              tiny;
        logic              gone;
        logic [11:0]       qr;
        logic signed [7:0] e;
        logic [15:0]       res;
        e    = exp;
        tiny = exp < -8'sd14;
        d    = 8'(-8'sd14 - exp);
        gone = tiny && (d > 8'd11);
        sh   = 5'd11;
        if (tiny && !gone)
        begin
            sh = 5'(8'd11 + d);
        end
        q    = mant >> sh;
        half = 22'd1 << (sh - 5'd1);
        rem  = mant & ((22'd1 << sh) - 22'd1);
        up   = (rem > half) || ((rem == half) && (sticky || q[0]));
        qr   = q[11:0] + {11'd0, up};
        if (gone)
        begin
            res = {sgn, 15'd0};
        end
        else if (tiny)
        begin
            res = {sgn, 15'(qr)};
        end
        else
        begin
            if (qr[11])
            begin
                qr = 12'h400;
                e  = exp + 8'sd1;
            end
            if (e > 8'sd15)
            begin
                res = {sgn, FP_INF};
            end
            else
            begin
                res = {sgn, 5'(e + 8'sd15), qr[9:0]};
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] fp_mul(input logic [15:0] a, input logic [15:0] b);
        logic              sgn;
        msfp_unp_t         ua;
        msfp_unp_t         ub;
        logic [21:0]       p;
        logic [21:0]       mant;
        logic signed [7:0] e;
        logic [15:0]       res;
        sgn  = a[15] ^ b[15];
        ua   = fp_unpack(a);
        ub   = fp_unpack(b);
        p    = 22'(ua.mant) * 22'(ub.mant);
        e    = ua.exp + ub.exp;
        mant = p << 1;
        if (p[21])
        begin
            e    = e + 8'sd1;
            mant = p;
        end
        if (fp_is_nan(a) || fp_is_nan(b))
        begin
            res = FP_QNAN;
        end
        else if ((fp_is_inf(a) && fp_is_zero(b)) || (fp_is_inf(b) && fp_is_zero(a)))
        begin
            res = FP_QNAN;
        end
        else if (fp_is_inf(a) || fp_is_inf(b))
        begin
            res = {sgn, FP_INF};
        end
        else if (fp_is_zero(a) || fp_is_zero(b))
        begin
            res = {sgn, 15'd0};
        end
        else
        begin
            res = fp_round(sgn, e, mant, 1'b0);
        end
        return res;
    endfunction

endpackage

[sv/msfp_div.sv]
module msfp_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [15:0] quo
);

    msfp_pkg::msfp_unp_t ua;
    msfp_pkg::msfp_unp_t ub;
    logic                run_reg;
    logic                run_next;
    logic [4:0]          cnt_reg;
    logic [4:0]          cnt_next;
    logic [11:0]         r_reg;
    logic [11:0]         r_next;
    logic [21:0]         q_reg;
    logic [21:0]         q_next;
    logic [10:0]         mb_reg;
    logic [10:0]         mb_next;
    logic signed [7:0]   e_reg;
    logic signed [7:0]   e_next;
    logic                s_reg;
    logic                s_next;
    logic                done_reg;
    logic                done_next;
    logic [15:0]         quo_reg;
    logic [15:0]         quo_next;
    logic                qbit;
    logic [11:0]         diff;
    logic                sgn;

    assign ua   = msfp_pkg::fp_unpack(num);
    assign ub   = msfp_pkg::fp_unpack(den);
    assign sgn  = num[15] ^ den[15];
    assign qbit = r_reg >= {1'b0, mb_reg};
    assign diff = qbit ? (r_reg - {1'b0, mb_reg}) : r_reg;

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        mb_next   = mb_reg;
        e_next    = e_reg;
        s_next    = s_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        if (start)
        begin
            s_next  = sgn;
            mb_next = ub.mant;
            q_next  = 22'd0;
            cnt_next = 5'd0;
            if (ua.mant < ub.mant)
            begin
                r_next = {ua.mant, 1'b0};
                e_next = ua.exp - ub.exp - 8'sd1;
            end
            else
            begin
                r_next = {1'b0, ua.mant};
                e_next = ua.exp - ub.exp;
            end
            if (msfp_pkg::fp_is_nan(num) || msfp_pkg::fp_is_nan(den) ||
                (msfp_pkg::fp_is_inf(num) && msfp_pkg::fp_is_inf(den)) ||
                (msfp_pkg::fp_is_zero(num) && msfp_pkg::fp_is_zero(den)))
            begin
                quo_next  = msfp_pkg::FP_QNAN;
                done_next = 1'b1;
            end
            else if (msfp_pkg::fp_is_inf(num) || msfp_pkg::fp_is_zero(den))
            begin
                quo_next  = {sgn, msfp_pkg::FP_INF};
                done_next = 1'b1;
            end
            else if (msfp_pkg::fp_is_zero(num) || msfp_pkg::fp_is_inf(den))
            begin
                quo_next  = {sgn, 15'd0};
                done_next = 1'b1;
            end
            else
            begin
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[20:0], qbit};
            r_next   = {diff[10:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd21)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                quo_next  = msfp_pkg::fp_round(s_reg, e_reg, {q_reg[20:0], qbit},
                                               diff != 12'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        mb_reg  <= mb_next;
        e_reg   <= e_next;
        s_reg   <= s_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[sv/msfp_derive.sv]
module msfp_derive
#(
    parameter int MAX_PASSES = 8,
    parameter int DIM_MAX    = 4096,
    parameter int PCW        = $clog2(MAX_PASSES + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    output msfp_pkg::msfp_cfg_t          cfg,
    output msfp_pkg::msfp_stat_t         stat,
    output logic [MAX_PASSES-1:0][15:0]  chain,
    output logic [PCW-1:0]               pass_count
);

    localparam logic [16:0] DIM_LIMIT = 17'(DIM_MAX);

    msfp_pkg::msfp_dstate_t         state_reg;
    msfp_pkg::msfp_dstate_t         state_next;
    msfp_pkg::msfp_kind_t           kind_reg;
    logic [11:0]                    kl_reg;
    logic [11:0]                    ku_reg;
    logic [15:0]                    from_reg;
    logic [15:0]                    to_reg;
    logic [12:0]                    m_reg;
    logic [12:0]                    n_reg;
    logic [14:0]                    ld_reg;
    msfp_pkg::msfp_err_t            err_reg;
    msfp_pkg::msfp_err_t            err_next;
    msfp_pkg::msfp_err_t            chk_err;
    logic [MAX_PASSES-1:0][15:0]    chain_reg;
    logic [MAX_PASSES-1:0][15:0]    chain_next;
    logic [PCW-1:0]                 pass_count_reg;
    logic [PCW-1:0]                 pass_count_next;
    logic [15:0]                    cf_reg;
    logic [15:0]                    cf_next;
    logic [15:0]                    ct_reg;
    logic [15:0]                    ct_next;
    logic [15:0]                    cf1;
    logic [15:0]                    ct1;
    logic                           sym;
    logic                           wr;
    logic                           div_start;
    logic                           div_done;
    logic [15:0]                    div_quo;
    logic                           app;
    logic [15:0]                    app_value;

    assign cfg_ready = state_reg == msfp_pkg::DS_IDLE;
    assign wr        = cfg_valid && cfg_ready;
    assign sym       = (kind_reg == msfp_pkg::KIND_BAND_LO) ||
                       (kind_reg == msfp_pkg::KIND_BAND_UP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= msfp_pkg::KIND_GENERAL;
            kl_reg   <= 12'd0;
            ku_reg   <= 12'd0;
            from_reg <= msfp_pkg::FP_ONE;
            to_reg   <= msfp_pkg::FP_ONE;
            m_reg    <= 13'd0;
            n_reg    <= 13'd0;
            ld_reg   <= 15'd1;
        end
        else if (wr)
        begin
            case (msfp_pkg::msfp_reg_t'(cfg_index))
                msfp_pkg::REG_KIND:      kind_reg <= msfp_pkg::msfp_kind_t'(cfg_data[2:0]);
                msfp_pkg::REG_SUBDIAG:   kl_reg   <= cfg_data[11:0];
                msfp_pkg::REG_SUPERDIAG: ku_reg   <= cfg_data[11:0];
                msfp_pkg::REG_FROM:      from_reg <= cfg_data;
                msfp_pkg::REG_TO:        to_reg   <= cfg_data;
                msfp_pkg::REG_ROWS:      m_reg    <= cfg_data[12:0];
                msfp_pkg::REG_COLS:      n_reg    <= cfg_data[12:0];
                msfp_pkg::REG_LDIM:      ld_reg   <= cfg_data[14:0];
                default:                 ld_reg   <= ld_reg;
            endcase
        end
    end

    always_comb
    begin
        if (kind_reg == msfp_pkg::KIND_INVALID)
        begin
            chk_err = msfp_pkg::ERR_KIND;
        end
        else if (msfp_pkg::fp_is_zero(from_reg) || msfp_pkg::fp_is_nan(from_reg))
        begin
            chk_err = msfp_pkg::ERR_FROM;
        end
        else if (msfp_pkg::fp_is_nan(to_reg))
        begin
            chk_err = msfp_pkg::ERR_TO;
        end
        else if (({4'd0, m_reg} > DIM_LIMIT) || ({4'd0, n_reg} > DIM_LIMIT) ||
                 (sym && (n_reg != m_reg)))
        begin
            chk_err = msfp_pkg::ERR_COLS;
        end
        else if (kind_reg <= msfp_pkg::KIND_HESS)
        begin
            chk_err = (({2'd0, m_reg} > ld_reg) || (ld_reg == 15'd0)) ?
                      msfp_pkg::ERR_LDIM : msfp_pkg::ERR_OK;
        end
        else if ((m_reg == 13'd0) ? (kl_reg != 12'd0) : ({1'b0, kl_reg} >= m_reg))
        begin
            chk_err = msfp_pkg::ERR_SUBDIAG;
        end
        else if (((n_reg == 13'd0) ? (ku_reg != 12'd0) : ({1'b0, ku_reg} >= n_reg)) ||
                 (sym && (kl_reg != ku_reg)))
        begin
            chk_err = msfp_pkg::ERR_SUPERDIAG;
        end
        else if (((kind_reg == msfp_pkg::KIND_BAND_LO) && ({3'd0, kl_reg} >= ld_reg)) ||
                 ((kind_reg == msfp_pkg::KIND_BAND_UP) && ({3'd0, ku_reg} >= ld_reg)) ||
                 ((kind_reg == msfp_pkg::KIND_BAND_GEN) &&
                  ((15'({kl_reg, 1'b0}) + 15'(ku_reg)) >= ld_reg)))
        begin
            chk_err = msfp_pkg::ERR_LDIM;
        end
        else
        begin
            chk_err = msfp_pkg::ERR_OK;
        end
    end

    assign cf1 = msfp_pkg::fp_mul(cf_reg, msfp_pkg::FP_SMALL);
    assign ct1 = msfp_pkg::fp_mul(ct_reg, msfp_pkg::FP_SMALL);

    always_comb
    begin
        state_next      = state_reg;
        err_next        = err_reg;
        chain_next      = chain_reg;
        pass_count_next = pass_count_reg;
        cf_next         = cf_reg;
        ct_next         = ct_reg;
        div_start       = 1'b0;
        app             = 1'b0;
        app_value       = msfp_pkg::FP_ONE;
        case (state_reg)
            msfp_pkg::DS_IDLE:
            begin
                if (wr)
                begin
                    state_next = msfp_pkg::DS_CHECK;
                end
            end
            msfp_pkg::DS_CHECK:
            begin
                for (int p = 0; p < MAX_PASSES; p++)
                begin
                    chain_next[p] = msfp_pkg::FP_ONE;
                end
                pass_count_next = '0;
                err_next        = chk_err;
                cf_next         = from_reg;
                ct_next         = to_reg;
                state_next      = (chk_err == msfp_pkg::ERR_OK) ?
                                  msfp_pkg::DS_STEP : msfp_pkg::DS_IDLE;
            end
            msfp_pkg::DS_STEP:
            begin
                if (pass_count_reg == PCW'(MAX_PASSES))
                begin
                    state_next = msfp_pkg::DS_IDLE;
                end
                else if (msfp_pkg::fp_eq(cf1, cf_reg))
                begin
                    div_start  = 1'b1;
                    state_next = msfp_pkg::DS_DIV;
                end
                else if (msfp_pkg::fp_eq(ct1, ct_reg))
                begin
                    app        = ct_reg != msfp_pkg::FP_ONE;
                    app_value  = ct_reg;
                    state_next = msfp_pkg::DS_IDLE;
                end
                else if ((cf1[14:0] > ct_reg[14:0]) && !msfp_pkg::fp_is_zero(ct_reg))
                begin
                    app       = 1'b1;
                    app_value = msfp_pkg::FP_SMALL;
                    cf_next   = cf1;
                end
                else if (ct1[14:0] > cf_reg[14:0])
                begin
                    app       = 1'b1;
                    app_value = {1'b0, 5'd29, 10'd0};
                    ct_next   = ct1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = msfp_pkg::DS_DIV;
                end
            end
            msfp_pkg::DS_DIV:
            begin
                if (div_done)
                begin
                    app        = div_quo != msfp_pkg::FP_ONE;
                    app_value  = div_quo;
                    state_next = msfp_pkg::DS_IDLE;
                end
            end
            default:
            begin
                state_next = msfp_pkg::DS_IDLE;
            end
        endcase
        if (app)
        begin
            for (int p = 0; p < MAX_PASSES; p++)
            begin
                if (PCW'(p) == pass_count_reg)
                begin
                    chain_next[p] = app_value;
                end
            end
            pass_count_next = pass_count_reg + PCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= msfp_pkg::DS_IDLE;
            err_reg        <= msfp_pkg::ERR_OK;
            pass_count_reg <= '0;
            for (int p = 0; p < MAX_PASSES; p++)
            begin
                chain_reg[p] <= msfp_pkg::FP_ONE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            pass_count_reg <= pass_count_next;
            chain_reg      <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cf_reg <= cf_next;
        ct_reg <= ct_next;
    end

    msfp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ct_reg),
        .den   (cf_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg.kind    = kind_reg;
    assign cfg.kl      = kl_reg;
    assign cfg.ku      = ku_reg;
    assign cfg.m       = m_reg;
    assign cfg.n       = n_reg;
    assign stat.busy   = state_reg != msfp_pkg::DS_IDLE;
    assign stat.err    = err_reg;
    assign chain       = chain_reg;
    assign pass_count  = pass_count_reg;

    a_div_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == msfp_pkg::DS_DIV |-> err_reg == msfp_pkg::ERR_OK)
        else $error("division running on an invalid setting");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_count_reg <= PCW'(MAX_PASSES))
        else $error("multiplier count beyond chain length");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == msfp_pkg::DS_DIV)
        else $error("division result outside the wait state");

endmodule

[sv/msfp_cell.sv]
module msfp_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  msfp_pkg::msfp_item_t in_item,
    input  logic [15:0]          mult,
    input  logic                 use_mult,
    output logic                 out_valid,
    output msfp_pkg::msfp_item_t out_item
);

    logic                 valid_reg;
    msfp_pkg::msfp_item_t item_reg;
    msfp_pkg::msfp_item_t item_next;

    always_comb
    begin
        item_next = in_item;
        if (in_item.active && use_mult)
        begin
            item_next.value = msfp_pkg::fp_mul(in_item.value, mult);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[sv/matrix_scale_safe_fp16.sv]
// Channel   Direction  Payload
// s_axis    in         tdata: elem_value, store_row, store_col
// m_axis    out        tdata: scaled_value, error_code
// cfg       in         cfg_index selects the register, cfg_data holds its value
//
// One item enters per cycle while s_axis_tready is high; its result passes through
// one registered cell per pass. After a register write the multipliers are derived,
// using the serial divider where needed; s_axis_tready is low meanwhile.
// After reset the chain holds the reset settings at once and no derivation runs.
// A stall on m_axis fills a one-item skid register, then freezes the chain and s_axis.
module matrix_scale_safe_fp16
#(
    parameter int MAX_PASSES = 8,
    parameter int DIM_MAX    = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // elem_value[15:0], store_row[29:16], store_col[41:30]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // scaled_value[15:0], error_code[18:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PCW = $clog2(MAX_PASSES + 1);

    msfp_pkg::msfp_cfg_t                     cfg;
    msfp_pkg::msfp_stat_t                    stat;
    logic [MAX_PASSES-1:0][15:0]             chain;
    logic [PCW-1:0]                          pass_count;
    logic [MAX_PASSES:0]                     vld;
    msfp_pkg::msfp_item_t [MAX_PASSES:0]     item;
    logic                                    pipe_en;
    logic                                    skid_full_reg;
    logic                                    skid_full_next;
    logic [15:0]                             skid_value_reg;
    logic [15:0]                             out_value;
    logic [15:0]                             i16;
    logic [15:0]                             j16;
    logic [15:0]                             kl16;
    logic [15:0]                             ku16;
    logic [15:0]                             m16;
    logic [15:0]                             n16;
    logic [15:0]                             ij;
    logic                                    in_pat;
    logic                                    row_ok;

    msfp_derive
    #(
        .MAX_PASSES (MAX_PASSES),
        .DIM_MAX    (DIM_MAX),
        .PCW        (PCW)
    )
    u_derive
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .stat       (stat),
        .chain      (chain),
        .pass_count (pass_count)
    );

    assign i16    = {2'd0, s_axis_tdata[29:16]};
    assign j16    = {4'd0, s_axis_tdata[41:30]};
    assign kl16   = {4'd0, cfg.kl};
    assign ku16   = {4'd0, cfg.ku};
    assign m16    = {3'd0, cfg.m};
    assign n16    = {3'd0, cfg.n};
    assign ij     = i16 + j16;
    assign row_ok = i16 < m16;

    always_comb
    begin
        case (cfg.kind)
            msfp_pkg::KIND_GENERAL:  in_pat = row_ok;
            msfp_pkg::KIND_LOWER:    in_pat = (i16 >= j16) && row_ok;
            msfp_pkg::KIND_UPPER:    in_pat = (i16 <= j16) && row_ok;
            msfp_pkg::KIND_HESS:     in_pat = (i16 <= j16 + 16'd1) && row_ok;
            msfp_pkg::KIND_BAND_LO:  in_pat = (i16 <= kl16) && (ij < n16);
            msfp_pkg::KIND_BAND_UP:  in_pat = (ij >= ku16) && (i16 <= ku16);
            msfp_pkg::KIND_BAND_GEN:
            begin
                in_pat = (i16 >= kl16) && (ij >= kl16 + ku16) &&
                         (i16 <= {kl16[14:0], 1'b0} + ku16) &&
                         (ij + 16'd1 <= kl16 + ku16 + m16);
            end
            default:                 in_pat = 1'b0;
        endcase
    end

    assign pipe_en       = !skid_full_reg;
    assign s_axis_tready = !skid_full_reg && !stat.busy;

    assign vld[0]         = s_axis_tvalid && s_axis_tready;
    assign item[0].value  = s_axis_tdata[15:0];
    assign item[0].active = (stat.err == msfp_pkg::ERR_OK) && (j16 < n16) &&
                            (m16 != 16'd0) && in_pat;

    for (genvar p = 0; p < MAX_PASSES; p++)
    begin : g_cell
        msfp_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (vld[p]),
            .in_item   (item[p]),
            .mult      (chain[p]),
            .use_mult  (PCW'(p) < pass_count),
            .out_valid (vld[p+1]),
            .out_item  (item[p+1])
        );
    end

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg)
        begin
            skid_full_next = !m_axis_tready;
        end
        else if (vld[MAX_PASSES] && !m_axis_tready)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_value_reg <= item[MAX_PASSES].value;
        end
    end

    assign out_value     = skid_full_reg ? skid_value_reg : item[MAX_PASSES].value;
    assign m_axis_tvalid = skid_full_reg || vld[MAX_PASSES];
    assign m_axis_tdata  = {5'd0, stat.err, out_value};

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid register filled without a stall");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && m_axis_tready |=> !skid_full_reg)
        else $error("skid register kept an item that was taken");

endmodule

[tb/msfp_checker.sv]
`timescale 1ns / 1ps

module msfp_checker
    import msfp_pkg::*;
#(
    parameter int MAX_PASSES = 8,
    parameter int DIM_MAX    = 4096
)
(
    input  logic        clk,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          pending,
    output int          failures,
    output int          results_seen
);

    typedef struct packed {
        logic [15:0] value;
        msfp_err_t   err;
    } scaled_item_t;

    scaled_item_t scaled_q[$];

    msfp_kind_t  kind;
    logic [11:0] kl;
    logic [11:0] ku;
    logic [15:0] from_h;
    logic [15:0] to_h;
    logic [12:0] rows;
    logic [12:0] cols;
    logic [14:0] ldim;
    logic [15:0] mult_chain [MAX_PASSES];
    int          chain_len;
    msfp_err_t   cfg_err;

    assign pending = scaled_q.size();

    function automatic real half_to_dbl(input logic [15:0] h);
        logic [63:0] b;
        logic [10:0] m;
        int          e;
        int          ee;
        e = h[14:10];
        m = {1'b0, h[9:0]};
        if (e == 31)
        begin
            b = {h[15], 11'h7FF, m[9:0], 42'd0};
        end
        else if (e == 0)
        begin
            if (m == 0)
            begin
                b = {h[15], 63'd0};
            end
            else
            begin
                ee = -14;
                while (!m[10])
                begin
                    m = m << 1;
                    ee--;
                end
                b = {h[15], 11'(ee + 1023), m[9:0], 42'd0};
            end
        end
        else
        begin
            b = {h[15], 11'(e - 15 + 1023), m[9:0], 42'd0};
        end
        return $bitstoreal(b);
    endfunction

    function automatic logic [15:0] dbl_to_half(input real x);
        logic [63:0] b;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [15:0] sg;
        longint      e;
        longint      shift;
        b  = $realtobits(x);
        sg = {b[63], 15'd0};
        e  = longint'(b[62:52]);
        if (e == 2047)
        begin
            return (b[51:0] != 0) ? FP_QNAN : (sg | 16'h7C00);
        end
        if (e == 0)
        begin
            return sg;
        end
        e     = e - 1023;
        sig   = {11'd1, b[51:0]};
        shift = 42;
        if (e < -14)
        begin
            shift = shift + (-14 - e);
        end
        if (shift > 60)
        begin
            return sg;
        end
        q    = sig >> shift;
        rem  = sig & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        if (e < -14)
        begin
            return sg | q[15:0];
        end
        if (q == 64'h800)
        begin
            q = q >> 1;
            e = e + 1;
        end
        if (e > 15)
        begin
            return sg | 16'h7C00;
        end
        return sg | 16'((e + 15) << 10) | (q[15:0] & 16'h3FF);
    endfunction

    function automatic real rnd16(input real x);
        return half_to_dbl(dbl_to_half(x));
    endfunction

    function automatic real absr(input real x);
        return (x < 0.0) ? -x : x;
    endfunction

    function automatic logic nan16(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic msfp_err_t settings_error();
        longint m;
        longint n;
        longint a;
        longint b;
        longint ld;
        logic   sym;
        m   = rows;
        n   = cols;
        a   = kl;
        b   = ku;
        ld  = ldim;
        sym = (kind == KIND_BAND_LO) || (kind == KIND_BAND_UP);
        if (kind == KIND_INVALID)
            return ERR_KIND;
        if (from_h[14:0] == 15'd0 || nan16(from_h))
            return ERR_FROM;
        if (nan16(to_h))
            return ERR_TO;
        if (m > DIM_MAX || n > DIM_MAX || (sym && n != m))
            return ERR_COLS;
        if (kind <= KIND_HESS)
            return (ld < ((m > 1) ? m : 1)) ? ERR_LDIM : ERR_OK;
        if (a > ((m > 1) ? m - 1 : 0))
            return ERR_SUBDIAG;
        if (b > ((n > 1) ? n - 1 : 0) || (sym && a != b))
            return ERR_SUPERDIAG;
        if ((kind == KIND_BAND_LO && ld < a + 1) || (kind == KIND_BAND_UP && ld < b + 1) ||
            (kind == KIND_BAND_GEN && ld < 2 * a + b + 1))
            return ERR_LDIM;
        return ERR_OK;
    endfunction

    function automatic void build_chain();
        real  sm_min;
        real  sm_big;
        real  cf;
        real  ct;
        real  cf1;
        real  ct1;
        real  mul;
        logic done;
        sm_min = rnd16(1.0 / 16384.0);
        sm_big = rnd16(16384.0);
        done   = 1'b0;
        mul    = 1.0;
        for (int i = 0; i < MAX_PASSES; i++)
        begin
            mult_chain[i] = FP_ONE;
        end
        chain_len = 0;
        cfg_err   = settings_error();
        if (cfg_err != ERR_OK)
            return;
        cf = half_to_dbl(from_h);
        ct = half_to_dbl(to_h);
        while (!done && chain_len < MAX_PASSES)
        begin
            cf1 = rnd16(cf * sm_min);
            if (cf1 == cf)
            begin
                mul  = rnd16(ct / cf);
                done = 1'b1;
            end
            else
            begin
                ct1 = rnd16(ct / sm_big);
                if (ct1 == ct)
                begin
                    mul  = ct;
                    done = 1'b1;
                    cf   = 1.0;
                end
                else if (absr(cf1) > absr(ct) && ct != 0.0)
                begin
                    mul = sm_min;
                    cf  = cf1;
                end
                else if (absr(ct1) > absr(cf))
                begin
                    mul = sm_big;
                    ct  = ct1;
                end
                else
                begin
                    mul  = rnd16(ct / cf);
                    done = 1'b1;
                end
            end
            if (!done || mul != 1.0)
            begin
                mult_chain[chain_len] = dbl_to_half(mul);
                chain_len++;
            end
        end
    endfunction

    function automatic logic in_pattern(input longint i, input longint j);
        longint m;
        longint n;
        longint a;
        longint b;
        longint lo;
        longint hi;
        m = rows;
        n = cols;
        a = kl;
        b = ku;
        if (j >= n || m == 0)
            return 1'b0;
        case (kind)
            KIND_GENERAL: return i < m;
            KIND_LOWER:   return i >= j && i < m;
            KIND_UPPER:   return i <= j && i < m;
            KIND_HESS:    return i <= j + 1 && i < m;
            KIND_BAND_LO: return i <= a && i + j < n;
            KIND_BAND_UP: return i >= b - j && i <= b;
            KIND_BAND_GEN:
            begin
                lo = a + b - j;
                if (lo < a)
                    lo = a;
                hi = a + b + m - 1 - j;
                if (hi > 2 * a + b)
                    hi = 2 * a + b;
                return i >= lo && i <= hi;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic scaled_item_t scale_elem(input logic [47:0] d);
        scaled_item_t r;
        logic [15:0]  v;
        v = d[15:0];
        if (cfg_err == ERR_OK && in_pattern(longint'(d[29:16]), longint'(d[41:30])))
        begin
            for (int p = 0; p < chain_len; p++)
            begin
                if (nan16(v))
                begin
                    v = FP_QNAN;
                    break;
                end
                v = dbl_to_half(half_to_dbl(v) * half_to_dbl(mult_chain[p]));
            end
        end
        r.value = v;
        r.err   = cfg_err;
        return r;
    endfunction

    initial
    begin
        kind         = KIND_GENERAL;
        kl           = '0;
        ku           = '0;
        from_h       = FP_ONE;
        to_h         = FP_ONE;
        rows         = '0;
        cols         = '0;
        ldim         = 15'd1;
        failures     = 0;
        results_seen = 0;
        build_chain();
    end

    always @(posedge clk)
    begin
        scaled_item_t want;
        if (cfg_valid && cfg_ready)
        begin
            case (msfp_reg_t'(cfg_index))
                REG_KIND:      kind   = msfp_kind_t'(cfg_data[2:0]);
                REG_SUBDIAG:   kl     = cfg_data[11:0];
                REG_SUPERDIAG: ku     = cfg_data[11:0];
                REG_FROM:      from_h = cfg_data;
                REG_TO:        to_h   = cfg_data;
                REG_ROWS:      rows   = cfg_data[12:0];
                REG_COLS:      cols   = cfg_data[12:0];
                REG_LDIM:      ldim   = cfg_data[14:0];
                default:       ;
            endcase
            build_chain();
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            scaled_q.push_back(scale_elem(s_axis_tdata));
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (scaled_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected item: value %h error %0d",
                             m_axis_tdata[15:0], m_axis_tdata[18:16]);
            end
            else
            begin
                want = scaled_q.pop_front();
                if (m_axis_tdata[15:0] !== want.value || m_axis_tdata[18:16] !== want.err)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch at item %0d: expected value %h error %0d, got %h %0d",
                                 results_seen, want.value, want.err,
                                 m_axis_tdata[15:0], m_axis_tdata[18:16]);
                end
            end
        end
    end

endmodule

[tb/tb_matrix_scale_safe_fp16.sv]
`timescale 1ns / 1ps

module tb_matrix_scale_safe_fp16;
    import msfp_pkg::*;

    localparam int MAX_PASSES  = 8;
    localparam int DIM_MAX     = 4096;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          pending;
    int          failures;
    int          results_seen;
    int          items_sent;
    int          phases;
    int          cycles;
    logic        tx_quiet;
    logic        rx_quiet;

    matrix_scale_safe_fp16 #(.MAX_PASSES(MAX_PASSES), .DIM_MAX(DIM_MAX)) dut (.*);

    msfp_checker #(.MAX_PASSES(MAX_PASSES), .DIM_MAX(DIM_MAX)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("matrix_scale_safe_fp16 test failed");
                $finish;
            end
        end
    end

    function automatic int draw_gap(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = draw_gap(rx_quiet);
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    task automatic write_reg(input msfp_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_elem(input logic [15:0] val, input logic [13:0] row,
                             input logic [11:0] col);
        int w;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, col, row, val};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        w = draw_gap(tx_quiet);
        if (w > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (MAX_PASSES + 4) @(posedge clk);
    endtask

    task automatic load_cfg(input msfp_kind_t k, input logic [11:0] a, input logic [11:0] b,
                            input logic [15:0] fr, input logic [15:0] to_v,
                            input logic [12:0] m, input logic [12:0] n, input logic [14:0] ld);
        drain();
        write_reg(REG_KIND, 16'(k));
        write_reg(REG_SUBDIAG, 16'(a));
        write_reg(REG_SUPERDIAG, 16'(b));
        write_reg(REG_FROM, fr);
        write_reg(REG_TO, to_v);
        write_reg(REG_ROWS, 16'(m));
        write_reg(REG_COLS, 16'(n));
        write_reg(REG_LDIM, 16'(ld));
        phases++;
    endtask

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 13))
            0:       return FP_ONE;
            1:       return 16'h7BFF;
            2:       return 16'h0001;
            3:       return 16'hFBFF;
            4:       return 16'h7C00;
            5:       return 16'h8400;
            6:       return 16'h0000;
            7:       return 16'h7C01;
            8:       return 16'h03FF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_elem();
        if ($urandom_range(0, 4) == 0)
            return pick_half();
        return 16'($urandom());
    endfunction

    initial
    begin
        msfp_kind_t  k;
        logic [12:0] m;
        logic [12:0] n;
        logic [11:0] a;
        logic [11:0] b;
        logic [14:0] ld;
        int          cnt;
        int          rmax;
        int          cmax;
        logic [15:0] edge_vals [12];
        edge_vals = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFFFF,
                      16'h0001, 16'h7BFF, 16'h3C00, 16'h03FF, 16'h8001, 16'h5555};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_KIND;
        cfg_data      = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        items_sent    = 0;
        phases        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_elem(16'h3C00, 14'd0, 12'd0);
        send_elem(16'hFFFF, 14'h3FFF, 12'hFFF);

        load_cfg(KIND_GENERAL, 12'd0, 12'd0, 16'h0001, 16'h7BFF, 13'd4, 13'd4, 15'd4);
        foreach (edge_vals[i])
            send_elem(edge_vals[i], 14'(i % 5), 12'(i % 4));
        send_elem(16'h3C00, 14'h3FFF, 12'd0);
        send_elem(16'h3C00, 14'd0, 12'hFFF);
        load_cfg(KIND_INVALID, 12'hFFF, 12'hFFF, 16'h7C00, 16'h0000,
                 13'h1FFF, 13'h1FFF, 15'h7FFF);
        send_elem(16'h4000, 14'd1, 12'd1);
        load_cfg(KIND_BAND_GEN, 12'd2, 12'd1, 16'h7BFF, 16'h0001, 13'd4096, 13'd4096,
                 15'd6);
        for (int i = 0; i < 6; i++)
            send_elem(edge_vals[i + 6], 14'(i), 12'(i));

        while (items_sent < 1500)
        begin
            k  = msfp_kind_t'($urandom_range(0, 7));
            m  = 13'($urandom_range(0, 12));
            n  = (k == KIND_BAND_LO || k == KIND_BAND_UP) ? m : 13'($urandom_range(0, 12));
            case ($urandom_range(0, 15))
                0:       m = 13'd4096;
                1:       n = 13'($urandom_range(4097, 8191));
                2:       begin m = 13'd4096; n = 13'd4096; end
                default: ;
            endcase
            a  = 12'($urandom_range(0, (m > 1) ? ((m > 6) ? 6 : m - 1) : 0));
            b  = (k == KIND_BAND_LO || k == KIND_BAND_UP) ? a :
                 12'($urandom_range(0, (n > 1) ? ((n > 6) ? 6 : n - 1) : 0));
            if ($urandom_range(0, 9) == 0)
                a = 12'($urandom());
            if ($urandom_range(0, 9) == 0)
                b = 12'($urandom());
            ld = 15'((k <= KIND_HESS) ? ((m > 1) ? m : 1) : 2 * a + b + 1);
            ld = ld + 15'($urandom_range(0, 2));
            case ($urandom_range(0, 11))
                0:       ld = 15'($urandom());
                1:       ld = 15'h7FFF;
                2:       ld = 15'(ld - 2);
                default: ;
            endcase
            load_cfg(k, a, b, pick_half(), pick_half(), m, n, ld);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            rmax = int'(m) + 2 * a + b + 3;
            rmax = (rmax > 16383) ? 16383 : rmax;
            cmax = int'(n) + 2;
            cmax = (cmax > 4095) ? 4095 : cmax;
            cnt  = $urandom_range(10, 50);
            for (int i = 0; i < cnt; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_elem(pick_elem(), 14'($urandom()), 12'($urandom()));
                else
                    send_elem(pick_elem(), 14'($urandom_range(0, rmax)),
                              12'($urandom_range(0, cmax)));
            end
        end

        s_axis_tvalid <= 1'b0;
        rx_quiet = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (MAX_PASSES * 4) @(posedge clk);

        $display("Sent %0d elements over %0d register settings, checked %0d results.",
                 items_sent, phases, results_seen);
        if (failures == 0 && pending == 0)
        begin
            $display("matrix_scale_safe_fp16 test passed");
        end
        else
        begin
            $display("%0d failures, %0d results still expected", failures, pending);
            $display("matrix_scale_safe_fp16 test failed");
        end
        $finish;
    end

endmodule
